/* src/lcrq_pkg.sv */
// ----------------------------------------------------------------------------
// lcrq_pkg
// Shared request codes and per-cell control for the Lamport clock request
// queue.
// ----------------------------------------------------------------------------
package lcrq_pkg;

    localparam int STAMP_W = 32;
    localparam int REQ_W   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_RECEIVE = 3'd1,
        REQ_ENQUEUE = 3'd2,
        REQ_REMOVE  = 3'd3,
        REQ_QUERY   = 3'd4
    } req_type_t;

    typedef struct packed {
        logic enq;
        logic rem;
    } cell_op_t;

    localparam logic [STAMP_W-1:0] CLOCK_TOP   = '1;
    localparam logic [STAMP_W-1:0] CLOCK_RESET = 32'd1;

endpackage

/* src/lcrq_cell.sv */
// ----------------------------------------------------------------------------
// lcrq_cell
// One slot of the sorted queue: holds an entry, decides whether to keep it,
// take the left neighbor's, take the right neighbor's or take the new entry.
// ----------------------------------------------------------------------------
module lcrq_cell
    import lcrq_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_op_t           op,
    input  logic [STAMP_W-1:0] key_stamp,
    input  logic [ID_BITS-1:0] key_id,
    input  logic               key_kind,
    input  logic               left_ins,
    input  logic               left_hit,
    input  logic               left_valid,
    input  logic [STAMP_W-1:0] left_stamp,
    input  logic [ID_BITS-1:0] left_id,
    input  logic               left_kind,
    input  logic               right_valid,
    input  logic [STAMP_W-1:0] right_stamp,
    input  logic [ID_BITS-1:0] right_id,
    input  logic               right_kind,
    output logic               ins,
    output logic               hit,
    output logic               valid,
    output logic [STAMP_W-1:0] stamp,
    output logic [ID_BITS-1:0] id,
    output logic               kind,
    output logic               valid_next,
    output logic [ID_BITS-1:0] id_next,
    output logic               kind_next
);

    logic               valid_reg;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [ID_BITS-1:0] id_reg;
    logic               kind_reg;
    logic               after;

    always_comb begin
        if (stamp_reg != key_stamp) begin
            after = stamp_reg > key_stamp;
        end else begin
            after = id_reg > key_id;
        end
    end

    assign ins = !valid_reg || after;
    assign hit = left_hit || (valid_reg && (id_reg == key_id));

    always_comb begin
        valid_next = valid_reg;
        stamp_next = stamp_reg;
        id_next    = id_reg;
        kind_next  = kind_reg;
        if (op.enq && ins) begin
            if (left_ins) begin
                valid_next = left_valid;
                stamp_next = left_stamp;
                id_next    = left_id;
                kind_next  = left_kind;
            end else begin
                valid_next = 1'b1;
                stamp_next = key_stamp;
                id_next    = key_id;
                kind_next  = key_kind;
            end
        end else if (op.rem && hit) begin
            valid_next = right_valid;
            stamp_next = right_stamp;
            id_next    = right_id;
            kind_next  = right_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg <= stamp_next;
        id_reg    <= id_next;
        kind_reg  <= kind_next;
    end

    assign valid = valid_reg;
    assign stamp = stamp_reg;
    assign id    = id_reg;
    assign kind  = kind_reg;

endmodule

/* src/lamport_clock_request_queue_top.sv */
// ----------------------------------------------------------------------------
// lamport_clock_request_queue_top
// Lamport logical clock with a timestamp-ordered request queue built as a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The result word is registered; it is shown in the cycle after its request is accepted.
// Throughput: one request word per cycle while the result channel is not stalled;
// every cell compares and shifts in the same cycle, so insert and remove finish in one step.
// Reset: clock returns to 1 and the queue empties; the output word is dropped.
// ----------------------------------------------------------------------------
module lamport_clock_request_queue_top
    import lcrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [STAMP_W-1:0] s_stamp,
    input  logic [ID_BITS-1:0] s_proc_id,
    input  logic               s_entry_kind,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAMP_W-1:0] m_clock_value,
    output logic [CNT_W-1:0]   m_queue_count,
    output logic               m_id_is_first,
    output logic               m_id_is_second,
    output logic               m_second_is_boxer,
    output logic               m_overflow
);

    logic               accept;
    logic               full;
    cell_op_t           op;
    logic [STAMP_W-1:0] clock_reg, clock_next, clock_max;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf;

    logic               m_valid_reg, m_valid_next;
    logic [STAMP_W-1:0] m_clock_reg;
    logic [CNT_W-1:0]   m_count_reg;
    logic               m_first_reg, m_second_reg, m_boxer_reg, m_ovf_reg;

    logic               c_ins   [QUEUE_DEPTH];
    logic               c_hit   [QUEUE_DEPTH];
    logic               c_valid [QUEUE_DEPTH];
    logic [STAMP_W-1:0] c_stamp [QUEUE_DEPTH];
    logic [ID_BITS-1:0] c_id    [QUEUE_DEPTH];
    logic               c_kind  [QUEUE_DEPTH];
    logic               n_valid [QUEUE_DEPTH];
    logic [ID_BITS-1:0] n_id    [QUEUE_DEPTH];
    logic               n_kind  [QUEUE_DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        op.enq = accept && (s_req_type == REQ_ENQUEUE) && !full;
        op.rem = accept && (s_req_type == REQ_REMOVE);
        ovf    = (s_req_type == REQ_ENQUEUE) && full;
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic               l_ins, l_hit, l_valid, l_kind;
            logic [STAMP_W-1:0] l_stamp;
            logic [ID_BITS-1:0] l_id;
            logic               r_valid, r_kind;
            logic [STAMP_W-1:0] r_stamp;
            logic [ID_BITS-1:0] r_id;

            if (g == 0) begin : g_left_edge
                assign l_ins   = 1'b0;
                assign l_hit   = 1'b0;
                assign l_valid = 1'b0;
                assign l_stamp = '0;
                assign l_id    = '0;
                assign l_kind  = 1'b0;
            end else begin : g_left
                assign l_ins   = c_ins[g-1];
                assign l_hit   = c_hit[g-1];
                assign l_valid = c_valid[g-1];
                assign l_stamp = c_stamp[g-1];
                assign l_id    = c_id[g-1];
                assign l_kind  = c_kind[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_right_edge
                assign r_valid = 1'b0;
                assign r_stamp = '0;
                assign r_id    = '0;
                assign r_kind  = 1'b0;
            end else begin : g_right
                assign r_valid = c_valid[g+1];
                assign r_stamp = c_stamp[g+1];
                assign r_id    = c_id[g+1];
                assign r_kind  = c_kind[g+1];
            end

            lcrq_cell #(
                .ID_BITS(ID_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .op          (op),
                .key_stamp   (s_stamp),
                .key_id      (s_proc_id),
                .key_kind    (s_entry_kind),
                .left_ins    (l_ins),
                .left_hit    (l_hit),
                .left_valid  (l_valid),
                .left_stamp  (l_stamp),
                .left_id     (l_id),
                .left_kind   (l_kind),
                .right_valid (r_valid),
                .right_stamp (r_stamp),
                .right_id    (r_id),
                .right_kind  (r_kind),
                .ins         (c_ins[g]),
                .hit         (c_hit[g]),
                .valid       (c_valid[g]),
                .stamp       (c_stamp[g]),
                .id          (c_id[g]),
                .kind        (c_kind[g]),
                .valid_next  (n_valid[g]),
                .id_next     (n_id[g]),
                .kind_next   (n_kind[g])
            );
        end
    endgenerate

    assign clock_max = (clock_reg > s_stamp) ? clock_reg : s_stamp;

    always_comb begin
        clock_next = clock_reg;
        count_next = count_reg;
        case (s_req_type)
            REQ_TICK: begin
                clock_next = (clock_reg == CLOCK_TOP) ? CLOCK_TOP : clock_reg + 1'b1;
            end
            REQ_RECEIVE: begin
                clock_next = (clock_max == CLOCK_TOP) ? CLOCK_TOP : clock_max + 1'b1;
            end
            REQ_ENQUEUE: begin
                if (!full) begin
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (c_hit[QUEUE_DEPTH-1]) begin
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                clock_next = clock_reg;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg   <= CLOCK_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                clock_reg <= clock_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_clock_reg  <= clock_next;
            m_count_reg  <= count_next;
            m_first_reg  <= n_valid[0] && (n_id[0] == s_proc_id);
            m_second_reg <= n_valid[1] && (n_id[1] == s_proc_id);
            m_boxer_reg  <= n_valid[1] && n_kind[1];
            m_ovf_reg    <= ovf;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_clock_value     = m_clock_reg;
    assign m_queue_count     = m_count_reg;
    assign m_id_is_first     = m_first_reg;
    assign m_id_is_second    = m_second_reg;
    assign m_second_is_boxer = m_boxer_reg;
    assign m_overflow        = m_ovf_reg;

endmodule

/* test/lamport_queue_checker.sv */
// ----------------------------------------------------------------------------
// lamport_queue_checker
// Watches the request and result channels of the Lamport clock request queue.
// Keeps its own copy of the logical clock and the sorted queue, works out the
// expected result word for each accepted request word and compares every
// accepted result word field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module lamport_queue_checker
    import lcrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [STAMP_W-1:0] s_stamp,
    input  logic [ID_BITS-1:0] s_proc_id,
    input  logic               s_entry_kind,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [STAMP_W-1:0] m_clock_value,
    input  logic [CNT_W-1:0]   m_queue_count,
    input  logic               m_id_is_first,
    input  logic               m_id_is_second,
    input  logic               m_second_is_boxer,
    input  logic               m_overflow,
    output int                 fail_count,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAMP_W-1:0] clock_value;
        logic [CNT_W-1:0]   queue_count;
        logic               id_is_first;
        logic               id_is_second;
        logic               second_is_boxer;
        logic               overflow;
    } queue_report_t;

    logic [STAMP_W-1:0] lamport_time;
    logic [STAMP_W-1:0] held_stamp [QUEUE_DEPTH];
    logic [ID_BITS-1:0] held_id    [QUEUE_DEPTH];
    logic               held_kind  [QUEUE_DEPTH];
    int                 held_count;
    queue_report_t      awaited_reports [$];

    function automatic logic [STAMP_W-1:0] saturating_bump(input logic [STAMP_W-1:0] v);
        return (v == CLOCK_TOP) ? CLOCK_TOP : v + 1'b1;
    endfunction

    function automatic queue_report_t apply_request(
        input logic [REQ_W-1:0]   code,
        input logic [STAMP_W-1:0] stamp,
        input logic [ID_BITS-1:0] id,
        input logic               kind
    );
        queue_report_t r;
        int            pos;
        int            hit;
        r = '0;
        case (code)
            REQ_TICK: begin
                lamport_time = saturating_bump(lamport_time);
            end
            REQ_RECEIVE: begin
                lamport_time = saturating_bump(stamp > lamport_time ? stamp : lamport_time);
            end
            REQ_ENQUEUE: begin
                if (held_count >= QUEUE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    // equal keys stay behind earlier arrivals
                    pos = 0;
                    while (pos < held_count &&
                           !(held_stamp[pos] > stamp ||
                             (held_stamp[pos] == stamp && held_id[pos] > id)))
                        pos++;
                    for (int j = held_count; j > pos; j--) begin
                        held_stamp[j] = held_stamp[j-1];
                        held_id[j]    = held_id[j-1];
                        held_kind[j]  = held_kind[j-1];
                    end
                    held_stamp[pos] = stamp;
                    held_id[pos]    = id;
                    held_kind[pos]  = kind;
                    held_count++;
                end
            end
            REQ_REMOVE: begin
                hit = -1;
                for (int i = held_count - 1; i >= 0; i--)
                    if (held_id[i] == id) hit = i;
                if (hit >= 0) begin
                    for (int j = hit; j < held_count - 1; j++) begin
                        held_stamp[j] = held_stamp[j+1];
                        held_id[j]    = held_id[j+1];
                        held_kind[j]  = held_kind[j+1];
                    end
                    held_count--;
                end
            end
            default: begin
            end
        endcase
        r.clock_value     = lamport_time;
        r.queue_count     = CNT_W'(held_count);
        r.id_is_first     = held_count >= 1 && held_id[0] == id;
        r.id_is_second    = held_count >= 2 && held_id[1] == id;
        r.second_is_boxer = held_count >= 2 && held_kind[1];
        return r;
    endfunction

    task automatic check_field(
        input string              name,
        input logic [STAMP_W-1:0] want,
        input logic [STAMP_W-1:0] got
    );
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        queue_report_t want;
        queue_report_t got;
        if (!aresetn) begin
            lamport_time = CLOCK_RESET;
            held_count   = 0;
            awaited_reports.delete();
        end else begin
            if (s_valid && s_ready)
                awaited_reports.insert(awaited_reports.size(),
                    apply_request(s_req_type, s_stamp, s_proc_id, s_entry_kind));
            if (m_valid && m_ready) begin
                got = {m_clock_value, m_queue_count, m_id_is_first, m_id_is_second,
                       m_second_is_boxer, m_overflow};
                if (awaited_reports.size() == 0) begin
                    $display("%0t: result word with none outstanding, expected none actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("clock_value", want.clock_value, got.clock_value);
                    check_field("queue_count", STAMP_W'(want.queue_count),
                                STAMP_W'(got.queue_count));
                    check_field("id_is_first", STAMP_W'(want.id_is_first),
                                STAMP_W'(got.id_is_first));
                    check_field("id_is_second", STAMP_W'(want.id_is_second),
                                STAMP_W'(got.id_is_second));
                    check_field("second_is_boxer", STAMP_W'(want.second_is_boxer),
                                STAMP_W'(got.second_is_boxer));
                    check_field("overflow", STAMP_W'(want.overflow),
                                STAMP_W'(got.overflow));
                end
            end
        end
        outstanding = awaited_reports.size();
    end

endmodule

/* test/lamport_clock_request_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// lamport_clock_request_queue_top_tb
// Drives request words into the Lamport clock request queue: a directed
// opening over ordering, ties, removal and unused codes, random traffic that
// swings the queue between empty and full under four idle/stall mixes, and a
// closing run that drives the clock into saturation. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module lamport_clock_request_queue_top_tb
    import lcrq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int ID_W       = 8;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int PHASE_LEN  = 200;
    localparam int QUIET_MAX  = 20000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [REQ_W-1:0]   s_req_type;
    logic [STAMP_W-1:0] s_stamp;
    logic [ID_W-1:0]    s_proc_id;
    logic               s_entry_kind;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [STAMP_W-1:0] m_clock_value;
    logic [CNT_W-1:0]   m_queue_count;
    logic               m_id_is_first;
    logic               m_id_is_second;
    logic               m_second_is_boxer;
    logic               m_overflow;

    int fail_count;
    int outstanding;
    int send_idle  = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    always #1 aclk = ~aclk;

    lamport_clock_request_queue_top #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (ID_W)
    ) dut (.*);

    lamport_queue_checker #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (ID_W)
    ) checker_i (.*);

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_MAX) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_request(
        input logic [REQ_W-1:0]   code,
        input logic [STAMP_W-1:0] stamp,
        input logic [ID_W-1:0]    id,
        input logic               kind
    );
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= code;
        s_stamp      <= stamp;
        s_proc_id    <= id;
        s_entry_kind <= kind;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(99) < 85) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
    endfunction

    task automatic send_random(input bit fill_bias);
        int                 pick;
        logic [REQ_W-1:0]   code;
        logic [STAMP_W-1:0] stamp;
        pick  = $urandom_range(99);
        stamp = $urandom;
        if (pick < (fill_bias ? 45 : 15)) begin
            code = REQ_ENQUEUE;
            if ($urandom_range(99) < 70) stamp = $urandom_range(15);
        end else if (pick < 60) begin
            code = REQ_REMOVE;
        end else if (pick < 70) begin
            code = REQ_TICK;
        end else if (pick < 80) begin
            code = REQ_RECEIVE;
            if ($urandom_range(99) < 60) stamp = $urandom_range(1000);
        end else if (pick < 94) begin
            code = REQ_QUERY;
        end else begin
            code = REQ_W'($urandom_range(REQ_QUERY + 1, (1 << REQ_W) - 1));
        end
        send_request(code, stamp, pick_id(), 1'($urandom));
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_QUERY;
        s_stamp      = '0;
        s_proc_id    = '0;
        s_entry_kind = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(REQ_QUERY, '0, '0, 1'b0);
        send_request(REQ_REMOVE, '0, 8'd9, 1'b0);
        send_request(REQ_TICK, '0, '0, 1'b0);
        send_request(REQ_RECEIVE, 32'd5, '0, 1'b0);
        send_request(REQ_RECEIVE, '0, '0, 1'b0);
        send_request(REQ_ENQUEUE, 32'd10, 8'd3, 1'b1);
        send_request(REQ_ENQUEUE, 32'd10, 8'd3, 1'b0);
        send_request(REQ_ENQUEUE, 32'd10, 8'd1, 1'b0);
        send_request(REQ_ENQUEUE, 32'd5, 8'd7, 1'b1);
        send_request(REQ_ENQUEUE, '0, '1, 1'b1);
        send_request(REQ_ENQUEUE, '1, '0, 1'b0);
        send_request(REQ_QUERY, '0, '1, 1'b0);
        send_request(REQ_QUERY, '0, 8'd7, 1'b0);
        send_request(REQ_REMOVE, '0, 8'd3, 1'b0);
        send_request(REQ_QUERY, '0, 8'd3, 1'b0);
        send_request(REQ_REMOVE, '0, '1, 1'b0);
        send_request(REQ_REMOVE, '0, 8'd200, 1'b0);
        for (int c = REQ_QUERY + 1; c < (1 << REQ_W); c++)
            send_request(REQ_W'(c), '1, 8'd7, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 81; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 81; end
                default: begin send_idle = 31; recv_stall = 31; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++)
                send_random(((n / 40) % 2) == 0);
        end

        // saturate the clock last so the random part sees it moving
        send_idle  = 0;
        recv_stall = 0;
        send_request(REQ_RECEIVE, 32'hFFFF_FFFE, '0, 1'b0);
        send_request(REQ_TICK, '0, '0, 1'b0);
        send_request(REQ_TICK, '0, '0, 1'b0);
        send_request(REQ_RECEIVE, '1, '0, 1'b0);
        send_request(REQ_RECEIVE, '0, '0, 1'b0);
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
